/* sv/tcd_pkg.sv */
// ----------------------------------------------------------------------------
// Track change detector package
// Shared widths, codes and types of the IoU track change detector.
// ----------------------------------------------------------------------------
package tcd_pkg;

    localparam int MAX_OBJECTS_DEF = 64;
    localparam int COORD_BITS_DEF  = 16;
    localparam int THR_W           = 17;
    localparam int KEY_W           = 40;
    localparam logic [THR_W-1:0] THR_RESET = 17'd32768;

    typedef enum logic [1:0] {
        CMD_ENTRY     = 2'd0,
        CMD_ENTRY_END = 2'd1,
        CMD_END       = 2'd2,
        CMD_CLEAR     = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_AREA,
        ST_PROD,
        ST_WRITE,
        ST_FINISH,
        ST_RESULT
    } state_t;

endpackage

/* sv/tcd_queue.sv */
// ----------------------------------------------------------------------------
// Track change detector request queue
// Two-entry queue that decouples the front classifier from the back engine.
// ----------------------------------------------------------------------------
module tcd_queue #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wp_reg;
    logic             rp_reg;
    logic [1:0]       cnt_reg;
    logic             push;
    logic             pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = mem_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) begin
                wp_reg <= ~wp_reg;
            end
            if (pop) begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= in_data;
        end
    end

endmodule

/* sv/tcd_front.sv */
// ----------------------------------------------------------------------------
// Track change detector front end
// Accepts input requests, drops untracked entries and forms the work word.
// ----------------------------------------------------------------------------
module tcd_front #(
    parameter int COORD_BITS = tcd_pkg::COORD_BITS_DEF,
    parameter int WW         = 2 + 1 + tcd_pkg::KEY_W + 4 * COORD_BITS
) (
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              cmd,
    input  logic [7:0]              class_code,
    input  logic [31:0]             obj_id,
    input  logic [4*COORD_BITS-1:0] box,
    output logic                    q_valid,
    input  logic                    q_ready,
    output logic [WW-1:0]           q_data
);

    logic has_entry;

    // An entry is kept only when it carries a track identity.
    assign has_entry = ((cmd == tcd_pkg::CMD_ENTRY) || (cmd == tcd_pkg::CMD_ENTRY_END))
                       && (obj_id != 32'd0);
    assign s_ready = q_ready;
    assign q_valid = s_valid && !((cmd == tcd_pkg::CMD_ENTRY) && !has_entry);
    assign q_data  = {box, class_code, obj_id, has_entry, cmd};

endmodule

/* sv/tcd_back.sv */
// ----------------------------------------------------------------------------
// Track change detector back end
// Matches keys in parallel cells, computes IoU in an area step and a product step, keeps
// the two table banks and forms the frame result.
// ----------------------------------------------------------------------------
module tcd_back #(
    parameter int MAX_OBJECTS = tcd_pkg::MAX_OBJECTS_DEF,
    parameter int COORD_BITS  = tcd_pkg::COORD_BITS_DEF,
    parameter int WW          = 2 + 1 + tcd_pkg::KEY_W + 4 * COORD_BITS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [tcd_pkg::THR_W-1:0] thr,
    input  logic                     q_valid,
    output logic                     q_ready,
    input  logic [WW-1:0]            q_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [1:0]               m_data
);

    localparam int N  = 2 * MAX_OBJECTS;
    localparam int IW = (N > 1) ? $clog2(N) : 1;
    localparam int SW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
    localparam int CB = COORD_BITS;
    localparam int DW = CB + 2;
    localparam int AW = 2 * DW + 2;
    localparam int PW = AW + 17;
    localparam int KW = tcd_pkg::KEY_W;

    tcd_pkg::state_t state_reg, state_next;

    logic [KW-1:0]     key_reg   [N];
    logic [4*CB-1:0]   boxs_reg  [N];
    logic [N-1:0]      valid_reg;
    logic [MAX_OBJECTS-1:0] seen_reg;
    logic              bank_reg;
    logic              pint_reg;
    logic              povf_reg;
    logic [1:0]        res_reg;
    logic              rv_reg;

    logic [1:0]        cmd;
    logic              has_entry;
    logic [KW-1:0]     key;
    logic [4*CB-1:0]   box;

    logic              found_reg;
    logic [SW-1:0]     fidx_reg;
    logic              wfound_reg;
    logic [SW-1:0]     widx_reg;
    logic [4*CB-1:0]   sbox_reg;
    logic signed [AW-1:0] ov_reg, un_reg;
    logic [PW-1:0]     lhs_reg, rhs_reg;

    logic [MAX_OBJECTS-1:0] smatch, wmatch, wfree;
    logic              sfound, wfound, anyfree;
    logic [SW-1:0]     sidx, widx, fridx;
    logic              vanished;

    assign cmd       = q_data[1:0];
    assign has_entry = q_data[2];
    assign key       = {q_data[42:35], q_data[34:3]};
    assign box       = q_data[WW-1:43];

    always_comb begin
        for (int i = 0; i < MAX_OBJECTS; i++) begin
            smatch[i] = valid_reg[IW'(bank_reg) * IW'(MAX_OBJECTS) + IW'(i)]
                        && key_reg[IW'(bank_reg) * IW'(MAX_OBJECTS) + IW'(i)] == key;
            wmatch[i] = valid_reg[IW'(!bank_reg) * IW'(MAX_OBJECTS) + IW'(i)]
                        && key_reg[IW'(!bank_reg) * IW'(MAX_OBJECTS) + IW'(i)] == key;
            wfree[i]  = !valid_reg[IW'(!bank_reg) * IW'(MAX_OBJECTS) + IW'(i)];
        end
        sfound = 1'b0;
        wfound = 1'b0;
        anyfree = 1'b0;
        sidx = '0;
        widx = '0;
        fridx = '0;
        for (int i = MAX_OBJECTS - 1; i >= 0; i--) begin
            if (smatch[i]) begin
                sfound = 1'b1;
                sidx = SW'(i);
            end
            if (wmatch[i]) begin
                wfound = 1'b1;
                widx = SW'(i);
            end
            if (wfree[i]) begin
                anyfree = 1'b1;
                fridx = SW'(i);
            end
        end
        vanished = 1'b0;
        for (int i = 0; i < MAX_OBJECTS; i++) begin
            if (valid_reg[IW'(bank_reg) * IW'(MAX_OBJECTS) + IW'(i)] && !seen_reg[i]) begin
                vanished = 1'b1;
            end
        end
    end

    logic signed [DW-1:0] al, at, ar, ab, bl, bt, br, bb, w, h, xl, xr, yt, yb;
    always_comb begin
        al = DW'(signed'(box[CB-1:0]));
        at = DW'(signed'(box[2*CB-1:CB]));
        ar = DW'(signed'(box[3*CB-1:2*CB]));
        ab = DW'(signed'(box[4*CB-1:3*CB]));
        bl = DW'(signed'(sbox_reg[CB-1:0]));
        bt = DW'(signed'(sbox_reg[2*CB-1:CB]));
        br = DW'(signed'(sbox_reg[3*CB-1:2*CB]));
        bb = DW'(signed'(sbox_reg[4*CB-1:3*CB]));
        xl = (al > bl) ? al : bl;
        xr = (ar < br) ? ar : br;
        yt = (at > bt) ? at : bt;
        yb = (ab < bb) ? ab : bb;
        w  = xr - xl;
        h  = yb - yt;
        if (w < 0) begin
            w = '0;
        end
        if (h < 0) begin
            h = '0;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tcd_pkg::ST_IDLE: begin
                if (q_valid) begin
                    if (cmd == tcd_pkg::CMD_CLEAR) begin
                        state_next = tcd_pkg::ST_IDLE;
                    end else if (has_entry) begin
                        state_next = tcd_pkg::ST_SCAN;
                    end else begin
                        state_next = tcd_pkg::ST_FINISH;
                    end
                end
            end
            tcd_pkg::ST_SCAN:   state_next = found_reg ? tcd_pkg::ST_AREA : tcd_pkg::ST_WRITE;
            tcd_pkg::ST_AREA:   state_next = tcd_pkg::ST_PROD;
            tcd_pkg::ST_PROD:   state_next = tcd_pkg::ST_WRITE;
            tcd_pkg::ST_WRITE: begin
                state_next = (cmd == tcd_pkg::CMD_ENTRY_END) ? tcd_pkg::ST_FINISH
                                                              : tcd_pkg::ST_IDLE;
            end
            tcd_pkg::ST_FINISH: state_next = tcd_pkg::ST_RESULT;
            tcd_pkg::ST_RESULT: state_next = (!rv_reg || m_ready) ? tcd_pkg::ST_IDLE
                                                                   : tcd_pkg::ST_RESULT;
            default:            state_next = tcd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        q_ready = 1'b0;
        case (state_reg)
            tcd_pkg::ST_IDLE:   q_ready = q_valid && (cmd == tcd_pkg::CMD_CLEAR);
            tcd_pkg::ST_WRITE:  q_ready = (cmd != tcd_pkg::CMD_ENTRY_END);
            tcd_pkg::ST_RESULT: q_ready = !rv_reg || m_ready;
            default:            q_ready = 1'b0;
        endcase
    end

    assign m_valid = rv_reg;
    assign m_data  = res_reg;

    logic moved;
    assign moved = (un_reg <= 0) ? (thr != '0) : (lhs_reg < rhs_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tcd_pkg::ST_IDLE;
            valid_reg <= '0;
            seen_reg  <= '0;
            bank_reg  <= 1'b0;
            pint_reg  <= 1'b0;
            povf_reg  <= 1'b0;
            rv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (rv_reg && m_ready) begin
                rv_reg <= 1'b0;
            end
            case (state_reg)
                tcd_pkg::ST_IDLE: begin
                    if (q_valid && cmd == tcd_pkg::CMD_CLEAR) begin
                        for (int i = 0; i < MAX_OBJECTS; i++) begin
                            valid_reg[IW'(bank_reg) * IW'(MAX_OBJECTS) + IW'(i)] <= 1'b0;
                        end
                        seen_reg <= '0;
                    end
                end
                tcd_pkg::ST_SCAN: begin
                    if (found_reg) begin
                        seen_reg[fidx_reg] <= 1'b1;
                    end else begin
                        pint_reg <= 1'b1;
                    end
                end
                tcd_pkg::ST_WRITE: begin
                    if (found_reg && moved) begin
                        pint_reg <= 1'b1;
                    end
                    if (wfound_reg || anyfree) begin
                        valid_reg[IW'(!bank_reg) * IW'(MAX_OBJECTS)
                                  + IW'(wfound_reg ? widx_reg : fridx)] <= 1'b1;
                    end else begin
                        povf_reg <= 1'b1;
                    end
                end
                tcd_pkg::ST_FINISH: begin
                    res_reg  <= {povf_reg, pint_reg || vanished};
                    rv_reg   <= 1'b1;
                    pint_reg <= 1'b0;
                    povf_reg <= 1'b0;
                    seen_reg <= '0;
                    for (int i = 0; i < MAX_OBJECTS; i++) begin
                        if (pint_reg || vanished) begin
                            valid_reg[IW'(bank_reg) * IW'(MAX_OBJECTS) + IW'(i)] <= 1'b0;
                        end else begin
                            valid_reg[IW'(!bank_reg) * IW'(MAX_OBJECTS) + IW'(i)] <= 1'b0;
                        end
                    end
                    if (pint_reg || vanished) begin
                        bank_reg <= ~bank_reg;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == tcd_pkg::ST_IDLE) begin
            found_reg  <= sfound;
            fidx_reg   <= sidx;
            wfound_reg <= wfound;
            widx_reg   <= widx;
            sbox_reg   <= boxs_reg[IW'(bank_reg) * IW'(MAX_OBJECTS) + IW'(sidx)];
        end
        if (state_reg == tcd_pkg::ST_AREA) begin
            ov_reg <= AW'(w) * AW'(h);
            un_reg <= AW'(ar - al) * AW'(ab - at) + AW'(br - bl) * AW'(bb - bt)
                      - AW'(w) * AW'(h);
        end
        if (state_reg == tcd_pkg::ST_PROD) begin
            lhs_reg <= {PW'(ov_reg)} << 16;
            rhs_reg <= PW'(un_reg[AW-2:0]) * PW'(thr);
        end
        if (state_reg == tcd_pkg::ST_WRITE && (wfound_reg || anyfree)) begin
            key_reg[IW'(!bank_reg) * IW'(MAX_OBJECTS) + IW'(wfound_reg ? widx_reg : fridx)]
                <= key;
            boxs_reg[IW'(!bank_reg) * IW'(MAX_OBJECTS) + IW'(wfound_reg ? widx_reg : fridx)]
                <= box;
        end
    end

endmodule

/* sv/track_change_detector_iou.sv */
// ----------------------------------------------------------------------------
// IoU track change detector
// Flags a video frame as interesting when a tracked object is new, moved
// or gone, keeping the last committed box table.
//
// channel  | dir | fields (lowest bit first)
// s_       | in  | tdata: cmd, class_code, object id, box l/t/r/b
// m_       | out | tdata: frame_interesting, table_overflow
// cfg_     | in  | match threshold (Q1.16)
//
// An entry with a stored key passes queue pick-up, key match, area, products
// and table write; an entry with a new key skips area and products; untracked
// entries are dropped at the input. A frame end passes queue pick-up, or an
// entry's table write, then finish and result, plus any wait on m_tready.
// Reset is synchronous and clears all control state and the valid bits.
// A two-entry queue lets one more request be taken while a result waits.
// ----------------------------------------------------------------------------
module track_change_detector_iou #(
    parameter int MAX_OBJECTS = tcd_pkg::MAX_OBJECTS_DEF,
    parameter int COORD_BITS  = tcd_pkg::COORD_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // cmd[1:0], class_code[9:2], object id[41:10], box_left, box_top,
    // box_right, box_bottom, then zero fill
    input  logic [((42 + 4 * COORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // frame_interesting[0], table_overflow[1], zero fill
    output logic [7:0]  m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [16:0] cfg_data
);

    localparam int WW = 2 + 1 + tcd_pkg::KEY_W + 4 * COORD_BITS;

    logic [tcd_pkg::THR_W-1:0] thr_reg;
    logic          q_in_valid, q_in_ready, q_valid, q_ready;
    logic [WW-1:0] q_in_data, q_data;
    logic [1:0]    res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= tcd_pkg::THR_RESET;
        end else if (cfg_valid) begin
            thr_reg <= cfg_data;
        end
    end

    tcd_front #(.COORD_BITS(COORD_BITS), .WW(WW)) u_front (
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .cmd        (s_tdata[1:0]),
        .class_code (s_tdata[9:2]),
        .obj_id     (s_tdata[41:10]),
        .box        (s_tdata[42 + 4 * COORD_BITS - 1:42]),
        .q_valid    (q_in_valid),
        .q_ready    (q_in_ready),
        .q_data     (q_in_data)
    );

    tcd_queue #(.WIDTH(WW)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_in_valid),
        .in_ready  (q_in_ready),
        .in_data   (q_in_data),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    tcd_back #(.MAX_OBJECTS(MAX_OBJECTS), .COORD_BITS(COORD_BITS), .WW(WW)) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .thr     (thr_reg),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_data  (res)
    );

    assign m_tdata = {6'd0, res};

endmodule
